[hdl/eqrs_pkg.sv]
// shared result type, tap constants and a helper function for the qrs pre-processing chain
`timescale 1ns / 1ps
`default_nettype none

package eqrs_pkg;

  localparam int unsigned DataWidth = 32;

  // delay line depths
  localparam int unsigned RawDepth = 12;
  localparam int unsigned LpDepth  = 32;
  localparam int unsigned HpDepth  = 4;

  // tap places in the newest-first delay lines
  localparam int unsigned RawTapMid  = 5;
  localparam int unsigned RawTapLast = 11;
  localparam int unsigned LpTapA     = 15;
  localparam int unsigned LpTapB     = 16;
  localparam int unsigned LpTapLast  = 31;
  localparam int unsigned HpTapMid   = 2;
  localparam int unsigned HpTapLast  = 3;

  // truncating divide shifts
  localparam logic [4:0] FilterShift = 5'd5;
  localparam logic [4:0] SlopeShift  = 5'd3;

  typedef struct packed {
    logic signed [DataWidth-1:0] lp;
    logic signed [DataWidth-1:0] hp;
    logic signed [DataWidth-1:0] slope;
    logic signed [DataWidth-1:0] sq;
  } res_t;

  // signed divide by a power of two, rounding toward zero
  function automatic logic signed [DataWidth-1:0] div_pow2(
    input logic signed [DataWidth-1:0] v,
    input logic [4:0]                  sh
  );
    logic signed [DataWidth-1:0] bias;
    bias = v[DataWidth-1] ? ((32'sd1 <<< sh) - 32'sd1) : 32'sd0;
    return (v + bias) >>> sh;
  endfunction

endpackage

`default_nettype wire

[hdl/ecg_qrs_preprocess_filter_chain.sv]
// qrs pre-processing chain: low-pass, high-pass, slope, square and window average
// an accepted item is held in the input register, then moves stage by stage to the output register
// throughput: one item per cycle while out_stall_i is low; eight register stages, each holding one item
// any empty stage lets the chain take a new item while a result waits at the output
// the window sum is kept as a running total, the divide is a reciprocal multiply
// reset clears all delay lines, running totals and valid bits to zero
`timescale 1ns / 1ps
`default_nettype none

module ecg_qrs_preprocess_filter_chain
  import eqrs_pkg::*;
#(
  parameter int unsigned WINDOW_LENGTH = 30,
  parameter int unsigned SAMPLE_WIDTH  = 12
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic signed [SAMPLE_WIDTH-1:0] sample_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic signed [DataWidth-1:0]         lowpass_value_o,
  output logic signed [DataWidth-1:0]         highpass_value_o,
  output logic signed [DataWidth-1:0]         slope_value_o,
  output logic signed [DataWidth-1:0]         squared_value_o,
  output logic signed [DataWidth-1:0]         window_average_o
);

  localparam int unsigned NumStages = 8;
  localparam int unsigned SqDepth   = WINDOW_LENGTH - 1;
  localparam logic [63:0] RecipFull = (64'd1 << 32) / 64'(WINDOW_LENGTH);
  localparam logic [DataWidth-1:0] Recip   = RecipFull[DataWidth-1:0];
  localparam logic [DataWidth-1:0] WinLen  = DataWidth'(WINDOW_LENGTH);

  // stage flow control
  logic [NumStages-1:0] vld_q;
  logic [NumStages-1:0] vin;
  logic [NumStages-1:0] ld;
  logic [NumStages:0]   rdy;

  always_comb begin
    rdy[NumStages] = !out_stall_i;
    for (int k = NumStages - 1; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
    vin = {vld_q[NumStages-2:0], in_valid_i};
    ld  = rdy[NumStages-1:0] & vin;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < NumStages; k++) begin
        if (rdy[k]) begin
          vld_q[k] <= vin[k];
        end
      end
    end
  end

  assign in_stall_o = !rdy[0];

  // stage 0: input register
  logic signed [SAMPLE_WIDTH-1:0] smp_q;

  always_ff @(posedge clk_i) begin
    if (ld[0]) begin
      smp_q <= sample_i;
    end
  end

  // stage 1: low-pass
  logic signed [SAMPLE_WIDTH-1:0] raw_q [RawDepth];
  logic signed [DataWidth-1:0]    lp1_q, lp2_q, lp_q;
  logic signed [DataWidth-1:0]    x_ext, x6_ext, x12_ext, lp_fir, lp_d;

  always_comb begin
    x_ext   = DataWidth'(smp_q);
    x6_ext  = DataWidth'(raw_q[RawTapMid]);
    x12_ext = DataWidth'(raw_q[RawTapLast]);
    lp_fir  = x_ext - (x6_ext <<< 1) + x12_ext;
    lp_d    = (lp1_q <<< 1) - lp2_q + div_pow2(lp_fir, FilterShift);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_q <= '{default: '0};
      lp1_q <= '0;
      lp2_q <= '0;
    end else if (ld[1]) begin
      raw_q[0] <= smp_q;
      for (int i = 1; i < RawDepth; i++) begin
        raw_q[i] <= raw_q[i-1];
      end
      lp1_q <= lp_d;
      lp2_q <= lp1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld[1]) begin
      lp_q <= lp_d;
    end
  end

  // stage 2: high-pass
  logic signed [DataWidth-1:0] lpl_q [LpDepth];
  logic signed [DataWidth-1:0] hp1_q;
  res_t                        r2_d, r2_q;

  always_comb begin
    r2_d    = '0;
    r2_d.lp = lp_q;
    r2_d.hp = hp1_q - div_pow2(lp_q, FilterShift) + lpl_q[LpTapA] - lpl_q[LpTapB]
              + div_pow2(lpl_q[LpTapLast], FilterShift);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lpl_q <= '{default: '0};
      hp1_q <= '0;
    end else if (ld[2]) begin
      lpl_q[0] <= lp_q;
      for (int i = 1; i < LpDepth; i++) begin
        lpl_q[i] <= lpl_q[i-1];
      end
      hp1_q <= r2_d.hp;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld[2]) begin
      r2_q <= r2_d;
    end
  end

  // stage 3: five-point slope
  logic signed [DataWidth-1:0] hpl_q [HpDepth];
  logic signed [DataWidth-1:0] slope_sum;
  res_t                        r3_d, r3_q;

  always_comb begin
    slope_sum = (r2_q.hp <<< 1) + hpl_q[0] - hpl_q[HpTapMid] - (hpl_q[HpTapLast] <<< 1);
    r3_d       = r2_q;
    r3_d.slope = div_pow2(slope_sum, SlopeShift);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hpl_q <= '{default: '0};
    end else if (ld[3]) begin
      hpl_q[0] <= r2_q.hp;
      for (int i = 1; i < HpDepth; i++) begin
        hpl_q[i] <= hpl_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld[3]) begin
      r3_q <= r3_d;
    end
  end

  // stage 4: square, low word of the product
  res_t r4_d, r4_q;

  always_comb begin
    r4_d    = r3_q;
    r4_d.sq = r3_q.slope * r3_q.slope;
  end

  always_ff @(posedge clk_i) begin
    if (ld[4]) begin
      r4_q <= r4_d;
    end
  end

  // stage 5: running window sum
  logic signed [DataWidth-1:0] sql_q [SqDepth];
  logic signed [DataWidth-1:0] part_q;
  logic signed [DataWidth-1:0] sum_d, sum_q;
  res_t                        r5_q;

  assign sum_d = r4_q.sq + part_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sql_q  <= '{default: '0};
      part_q <= '0;
    end else if (ld[5]) begin
      sql_q[0] <= r4_q.sq;
      for (int i = 1; i < SqDepth; i++) begin
        sql_q[i] <= sql_q[i-1];
      end
      part_q <= sum_d - sql_q[SqDepth-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld[5]) begin
      sum_q <= sum_d;
      r5_q  <= r4_q;
    end
  end

  // stage 6: magnitude and reciprocal multiply
  logic [DataWidth-1:0]   mag_d, mag_q, pr_q;
  logic [2*DataWidth-1:0] prod;
  logic                   neg_q;
  res_t                   r6_q;

  always_comb begin
    mag_d = sum_q[DataWidth-1] ? DataWidth'(-sum_q) : DataWidth'(sum_q);
    prod  = (2*DataWidth)'(mag_d) * (2*DataWidth)'(Recip);
  end

  always_ff @(posedge clk_i) begin
    if (ld[6]) begin
      mag_q <= mag_d;
      pr_q  <= prod[2*DataWidth-1:DataWidth];
      neg_q <= sum_q[DataWidth-1];
      r6_q  <= r5_q;
    end
  end

  // stage 7: quotient correction, sign and output register
  logic [DataWidth-1:0]        rem, quo;
  logic signed [DataWidth-1:0] avg_d, avg_q;
  res_t                        r7_q;

  always_comb begin
    rem   = mag_q - DataWidth'(pr_q * WinLen);
    quo   = pr_q + ((rem >= WinLen) ? DataWidth'(1) : DataWidth'(0));
    avg_d = neg_q ? -$signed(quo) : $signed(quo);
  end

  always_ff @(posedge clk_i) begin
    if (ld[7]) begin
      avg_q <= avg_d;
      r7_q  <= r6_q;
    end
  end

  assign out_valid_o      = vld_q[NumStages-1];
  assign lowpass_value_o  = r7_q.lp;
  assign highpass_value_o = r7_q.hp;
  assign slope_value_o    = r7_q.slope;
  assign squared_value_o  = r7_q.sq;
  assign window_average_o = avg_q;

  // checks
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (&vld_q))
    else $error("input stalled while a stage is empty");

  a_accept_loads_stage0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> vld_q[0])
    else $error("accepted item not held in the input register");

  a_recip_no_overshoot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[6] |-> ((64'(pr_q) * 64'(WINDOW_LENGTH)) <= 64'(mag_q)))
    else $error("window quotient estimate too large");

  a_output_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[6] && rdy[7]) |=> out_valid_o)
    else $error("result lost before the output register");

endmodule

`default_nettype wire
